>>> rtl/pet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic event timer table package
// Shared codes, result layout and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pet_pkg;

  localparam int SLOTS_DEF = 16;

  localparam logic [2:0] OP_ADD_PERIODIC = 3'd0;
  localparam logic [2:0] OP_ADD_ONCE     = 3'd1;
  localparam logic [2:0] OP_DELETE       = 3'd2;
  localparam logic [2:0] OP_RUN          = 3'd3;
  localparam logic [2:0] OP_QUERY        = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_NONE      = 2'd3;

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [31:0] fired_tag;
    logic [31:0] time_value;
    logic [6:0]  active_count;
    logic        last;
  } res_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic op_legal;
    logic hit;
    logic at_end;
    logic pend_v;
    logic out_free;
    logic is_run;
    logic is_addel;
  } sts_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? TIME_MAX : s[31:0];
  endfunction

endpackage

>>> rtl/pet_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic event timer table controller
// Sequences accept, slot scan and final result of each transaction.
// ----------------------------------------------------------------------------
module pet_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  pet_pkg::sts_t sts,
  output pet_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_END  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       run_blocked;

  // A second fired slot in a run must wait until the held one can move out.
  assign run_blocked = sts.hit && sts.is_run && sts.pend_v && !sts.out_free;
  assign in_stall    = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && sts.op_legal) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!run_blocked) begin
          cmd.scan = 1'b1;
          if (sts.at_end || (sts.hit && sts.is_addel)) begin
            state_nxt = S_END;
          end
        end
      end
      S_END: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_SCAN))
    else $error("load did not enter the scan");

  a_finish_in_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (state_r == S_IDLE) && !in_stall)
    else $error("finish did not return to idle");

  a_scan_only_scanning: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> (state_r == S_SCAN) && !cmd.load && !cmd.finish)
    else $error("scan issued outside the scan state");

endmodule

>>> rtl/pet_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic event timer table datapath
// Slot memory, valid bits, scan index, held result and output register.
// ----------------------------------------------------------------------------
module pet_dp #(
  parameter int SLOTS = pet_pkg::SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [2:0]    in_operation,
  input  logic [31:0]   in_tag,
  input  logic [31:0]   in_delay,
  input  logic [31:0]   in_now,
  input  pet_pkg::cmd_t cmd,
  output pet_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    out_status,
  output logic [5:0]    out_slot,
  output logic [31:0]   out_fired_tag,
  output logic [31:0]   out_time_value,
  output logic [6:0]    out_active_count,
  output logic          out_last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] due;
    logic [31:0] period;
  } entry_t;

  entry_t          mem [SLOTS];
  entry_t          rd_r;
  entry_t          wr_data;
  logic            wr_en, rd_en;
  logic [IW-1:0]   rd_addr;

  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt, cnt_inc, cnt_dec;
  logic [IW-1:0]    idx_r, idx_nxt, idx_next;

  logic [2:0]  op_r;
  logic [31:0] tag_r, delay_r, now_r;

  pet_pkg::res_t pend_r, pend_nxt;
  logic          pend_v_r, pend_v_nxt;
  pet_pkg::res_t out_r;
  pet_pkg::res_t push_data;
  logic          push, out_valid_r, out_valid_nxt;

  logic        cur_valid, at_end, hit;
  logic        is_add, is_del, is_run, is_qry;
  logic [31:0] add_due, run_due;
  logic [5:0]  slot_ext;

  assign cur_valid = valid_r[idx_r];
  assign at_end    = (idx_r == IW'(SLOTS - 1));
  assign idx_next  = at_end ? '0 : idx_r + 1'b1;
  assign slot_ext  = 6'(idx_r);
  assign cnt_inc   = cnt_r + 1'b1;
  assign cnt_dec   = cnt_r - 1'b1;
  assign add_due   = pet_pkg::sat_add(now_r, delay_r);
  assign run_due   = pet_pkg::sat_add(now_r, rd_r.period);

  assign is_add = (op_r == pet_pkg::OP_ADD_PERIODIC) || (op_r == pet_pkg::OP_ADD_ONCE);
  assign is_del = (op_r == pet_pkg::OP_DELETE);
  assign is_run = (op_r == pet_pkg::OP_RUN);
  assign is_qry = (op_r == pet_pkg::OP_QUERY);

  always_comb begin
    hit = 1'b0;
    case (op_r)
      pet_pkg::OP_ADD_PERIODIC, pet_pkg::OP_ADD_ONCE: hit = !cur_valid;
      pet_pkg::OP_DELETE: hit = cur_valid && (rd_r.tag == tag_r);
      pet_pkg::OP_RUN:    hit = cur_valid && (rd_r.due <= now_r);
      pet_pkg::OP_QUERY:  hit = cur_valid && (!pend_v_r || (rd_r.due < pend_r.time_value));
      default:            hit = 1'b0;
    endcase
  end

  assign sts.op_legal = in_operation inside {[pet_pkg::OP_ADD_PERIODIC:pet_pkg::OP_QUERY]};
  assign sts.hit      = hit;
  assign sts.at_end   = at_end;
  assign sts.pend_v   = pend_v_r;
  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.is_run   = is_run;
  assign sts.is_addel = is_add || is_del;

  // The read register always holds the slot under evaluation: slot zero is
  // read at accept, and each scan step fetches the following slot.
  assign rd_en   = cmd.load || cmd.scan;
  assign rd_addr = cmd.scan ? idx_next : '0;

  always_comb begin
    valid_nxt  = valid_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    wr_en      = 1'b0;
    wr_data    = '0;
    push       = 1'b0;
    push_data  = '0;

    if (cmd.load) begin
      idx_nxt    = '0;
      pend_v_nxt = 1'b0;
    end

    if (cmd.scan) begin
      idx_nxt = idx_next;
      if (hit) begin
        pend_v_nxt = 1'b1;
        if (is_add) begin
          valid_nxt[idx_r] = 1'b1;
          cnt_nxt          = cnt_inc;
          wr_en            = 1'b1;
          wr_data.tag      = tag_r;
          wr_data.due      = add_due;
          wr_data.period   = (op_r == pet_pkg::OP_ADD_PERIODIC) ? delay_r : '0;
          pend_nxt = '{pet_pkg::ST_OK, slot_ext, 32'd0, add_due, 7'(cnt_inc), 1'b0};
        end else if (is_del) begin
          valid_nxt[idx_r] = 1'b0;
          cnt_nxt          = cnt_dec;
          pend_nxt = '{pet_pkg::ST_OK, slot_ext, 32'd0, 32'd0, 7'(cnt_dec), 1'b0};
        end else if (is_run) begin
          // The previously fired slot is not the final result; send it on.
          if (pend_v_r) begin
            push      = 1'b1;
            push_data = pend_r;
          end
          if (rd_r.period != '0) begin
            wr_en          = 1'b1;
            wr_data.tag    = rd_r.tag;
            wr_data.due    = run_due;
            wr_data.period = rd_r.period;
            pend_nxt = '{pet_pkg::ST_OK, slot_ext, rd_r.tag, run_due, 7'(cnt_r), 1'b0};
          end else begin
            valid_nxt[idx_r] = 1'b0;
            cnt_nxt          = cnt_dec;
            pend_nxt = '{pet_pkg::ST_OK, slot_ext, rd_r.tag, 32'd0, 7'(cnt_dec), 1'b0};
          end
        end else if (is_qry) begin
          pend_nxt = '{pet_pkg::ST_OK, slot_ext, 32'd0, rd_r.due, 7'(cnt_r), 1'b0};
        end
      end
    end

    if (cmd.finish) begin
      push = 1'b1;
      if (pend_v_r) begin
        push_data      = pend_r;
        push_data.last = 1'b1;
      end else begin
        push_data.active_count = 7'(cnt_r);
        push_data.last         = 1'b1;
        case (op_r)
          pet_pkg::OP_ADD_PERIODIC, pet_pkg::OP_ADD_ONCE: push_data.status = pet_pkg::ST_FULL;
          pet_pkg::OP_DELETE: push_data.status = pet_pkg::ST_NOT_FOUND;
          pet_pkg::OP_QUERY: begin
            push_data.status     = pet_pkg::ST_NONE;
            push_data.time_value = pet_pkg::TIME_MAX;
          end
          default: push_data.status = pet_pkg::ST_NONE;
        endcase
      end
    end

    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_r] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_operation;
      tag_r   <= in_tag;
      delay_r <= in_delay;
      now_r   <= in_now;
    end
    pend_r <= pend_nxt;
    if (push) begin
      out_r <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_slot         = out_r.slot;
  assign out_fired_tag    = out_r.fired_tag;
  assign out_time_value   = out_r.time_value;
  assign out_active_count = out_r.active_count;
  assign out_last         = out_r.last;

  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CW'($countones(valid_r)))
    else $error("active count disagrees with valid bits");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten while stalled");

  a_load_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !pend_v_r)
    else $error("held result survived a new transaction");

endmodule

>>> rtl/periodic_event_timer_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic event timer table
// Timer slots with add, delete, run of due events and next-time query.
// ----------------------------------------------------------------------------
//  Channel | Ports                                            | Direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid/in_stall, operation, tag, delay, now     | input
//  out     | out_valid/out_stall, status, slot, fired_tag,     | output
//          | time_value, active_count, last                    |
//
// A transaction has an accept step, a scan of the slots in order through the
// single read port of the slot memory, and a step that delivers the final
// result; add and delete stop at the matching slot.
// A run holds each fired slot until the next one is found, so stalls on the
// output hold the scan. Reset clears the valid bits at once; no clearing pass.
// in_stall is high from accept until the final result enters the output
// register.
module periodic_event_timer_table #(
  parameter int SLOTS = pet_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_tag,
  input  logic [31:0] in_delay,
  input  logic [31:0] in_now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [5:0]  out_slot,
  output logic [31:0] out_fired_tag,
  output logic [31:0] out_time_value,
  output logic [6:0]  out_active_count,
  output logic        out_last
);

  pet_pkg::cmd_t cmd;
  pet_pkg::sts_t sts;

  pet_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pet_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_operation     (in_operation),
    .in_tag           (in_tag),
    .in_delay         (in_delay),
    .in_now           (in_now),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_fired_tag    (out_fired_tag),
    .out_time_value   (out_time_value),
    .out_active_count (out_active_count),
    .out_last         (out_last)
  );

endmodule
